// ===== design/ccfs_pkg.sv =====
// Shared constants, types, color table and control structs for the color fade sequencer.
`default_nettype none

package ccfs_pkg;

    localparam int CHANNELS    = 4;
    localparam int COLOR_COUNT = 11;

    localparam int CH_W       = 2;
    localparam int COLOR_W    = 4;
    localparam int BRIGHT_W   = 8;
    localparam int FADE_W     = 16;
    localparam int TICKS_W    = 16;
    localparam int PWM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 9;
    localparam int TIME_W     = 32;
    localparam int CD_W       = 32;
    localparam int DIV_W      = 40;
    localparam int DVSR_W     = 9;

    localparam logic [COLOR_W-1:0] COLOR_RESET = 4'd10;
    localparam logic [COLOR_W-1:0] PREV_RESET  = 4'd9;
    localparam logic [COLOR_W-1:0] COLOR_LAST  = 4'd10;

    localparam logic [FADE_W-1:0]   FADE_RESET  = 16'd10;
    localparam logic [TICKS_W-1:0]  TICKS_RESET = 16'd100;
    localparam logic [PWM_W-1:0]    PWM_RESET   = 8'd8;
    localparam logic [BRIGHT_W-1:0] MAXB_RESET  = 8'd255;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_TIME = 3'd0,
        CFG_TICKS     = 3'd1,
        CFG_PWM       = 3'd2,
        CFG_MAX_0     = 3'd3,
        CFG_MAX_1     = 3'd4,
        CFG_MAX_2     = 3'd5,
        CFG_MAX_3     = 3'd6
    } t_cfg_idx;

    typedef logic [BRIGHT_W-1:0] t_bright;

    // RGBW color table, one row per color.
    localparam t_bright COLOR_TABLE [COLOR_COUNT][CHANNELS] = '{
        '{8'd128, 8'd0,   8'd0,  8'd0  },
        '{8'd95,  8'd255, 8'd0,  8'd0  },
        '{8'd0,   8'd255, 8'd0,  8'd0  },
        '{8'd0,   8'd255, 8'd0,  8'd180},
        '{8'd0,   8'd255, 8'd52, 8'd0  },
        '{8'd40,  8'd0,   8'd52, 8'd0  },
        '{8'd0,   8'd0,   8'd52, 8'd0  },
        '{8'd0,   8'd0,   8'd52, 8'd110},
        '{8'd0,   8'd123, 8'd52, 8'd0  },
        '{8'd0,   8'd0,   8'd0,  8'd255},
        '{8'd120, 8'd0,   8'd0,  8'd180}
    };

    // Table lookup; an out-of-range color reads as color zero.
    function automatic t_bright color_entry(input logic [COLOR_W-1:0] color,
                                            input logic [CH_W-1:0] ch);
        t_bright v;
        if (color < COLOR_W'(COLOR_COUNT)) begin
            v = COLOR_TABLE[color][ch];
        end else begin
            v = COLOR_TABLE[0][ch];
        end
        return v;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic clear_active;
        logic advance;
        logic scan;
        logic ch_next;
        logic load_cd;
        logic store_cd;
        logic load_time;
        logic store_time;
        logic emit;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic active;
        logic off_target;
        logic cd_zero;
        logic last_ch;
        logic span_zero;
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/ccfs_if.sv =====
// Valid/ready channel interfaces for tick beats in and dim command beats out.
`default_nettype none

interface ccfs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] brightness_0;
    logic [7:0] brightness_1;
    logic [7:0] brightness_2;
    logic [7:0] brightness_3;
    logic [7:0] master_brightness;

    modport source (
        output valid, kind, brightness_0, brightness_1, brightness_2, brightness_3,
               master_brightness,
        input  ready
    );
    modport sink (
        input  valid, kind, brightness_0, brightness_1, brightness_2, brightness_3,
               master_brightness,
        output ready
    );
endinterface

interface ccfs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [8:0]  step_count;
    logic        direction;
    logic [31:0] step_time;
    logic [3:0]  color_index;

    modport source (
        output valid, channel, step_count, direction, step_time, color_index,
        input  ready
    );
    modport sink (
        input  valid, channel, step_count, direction, step_time, color_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/ccfs_divider.sv =====
// Restoring divider, two quotient bits per cycle, shared by both reload divisions.
`default_nettype none

module ccfs_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ccfs_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [ccfs_pkg::DVSR_W-1:0] i_divisor,
    output logic                            o_done,
    output logic [ccfs_pkg::DIV_W-1:0]       o_quotient
);
    import ccfs_pkg::*;

    localparam int ITER  = DIV_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic [DIV_W-1:0]  r_q;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVSR_W:0]   s1;
    logic [DVSR_W:0]   s2;

    // One restoring step: returns the quotient bit over the new remainder.
    function automatic logic [DVSR_W:0] div_step(input logic [DVSR_W-1:0] rem,
                                                 input logic              nbit,
                                                 input logic [DVSR_W-1:0] dvsr);
        logic [DVSR_W:0] t;
        logic [DVSR_W:0] d;
        logic [DVSR_W:0] r;
        t = {rem, nbit};
        d = {1'b0, dvsr};
        if (t >= d) begin
            r = t - d;
            return {1'b1, r[DVSR_W-1:0]};
        end else begin
            return {1'b0, t[DVSR_W-1:0]};
        end
    endfunction

    // Two dependent steps per cycle, taking the dividend from its top end.
    always_comb begin
        s1 = div_step(r_rem, r_q[DIV_W-1], r_dvsr);
        s2 = div_step(s1[DVSR_W-1:0], r_q[DIV_W-2], r_dvsr);
    end

    // Quotient bits shift in from the bottom as dividend bits leave the top.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ITER - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-3:0], s1[DVSR_W], s2[DVSR_W]};
            r_rem <= s2[DVSR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ===== design/ccfs_datapath.sv =====
// Datapath: configuration, countdowns, color state, target and span math, output register.
`default_nettype none

module ccfs_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ccfs_in_if.sink                              i_in,
    ccfs_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [ccfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ccfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire ccfs_pkg::t_ctrl_cmd             i_cmd,
    output ccfs_pkg::t_dp_status                 o_status
);
    import ccfs_pkg::*;

    // Configuration registers.
    logic [FADE_W-1:0]  r_fade;
    logic [TICKS_W-1:0] r_ticks;
    logic [PWM_W-1:0]   r_pwm;
    t_bright            r_maxb [CHANNELS];

    // Sequencer state.
    logic [CD_W-1:0]    r_cd [CHANNELS];
    logic [COLOR_W-1:0] r_cur;
    logic [COLOR_W-1:0] r_prev;
    logic               r_active;

    // Captured tick and per-channel working registers.
    t_bright            r_b [CHANNELS];
    t_bright            r_master;
    logic [CH_W-1:0]    r_ch;
    t_bright            r_span;
    logic [STEP_W-1:0]  r_steps;
    logic               r_darken;
    logic [TIME_W-1:0]  r_time;

    // Output register.
    logic               r_out_valid;
    logic [CH_W-1:0]    r_o_channel;
    logic [STEP_W-1:0]  r_o_steps;
    logic               r_o_dir;
    logic [TIME_W-1:0]  r_o_time;
    logic [COLOR_W-1:0] r_o_color;

    logic               in_fire;
    logic               out_fire;
    t_bright            cur_raw;
    t_bright            prev_raw;
    t_bright            cur_entry;
    t_bright            prev_entry;
    t_bright            diff;
    logic [2*BRIGHT_W-1:0] target_prod;
    logic [2*BRIGHT_W-1:0] span_prod;
    t_bright            target;
    t_bright            b_now;
    logic               darken;
    logic [STEP_W-1:0]  steps;
    logic [CD_W-1:0]    cd_now;
    logic [CD_W-1:0]    ft_prod;
    logic [DIV_W-1:0]   ct_prod;
    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DVSR_W-1:0]  div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_q;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_fire = o_out.valid & o_out.ready;

    // Target and span of the channel being scanned, from clamped table entries.
    always_comb begin
        cur_raw     = color_entry(r_cur, r_ch);
        prev_raw    = color_entry(r_prev, r_ch);
        cur_entry   = (cur_raw > r_maxb[r_ch]) ? r_maxb[r_ch] : cur_raw;
        prev_entry  = (prev_raw > r_maxb[r_ch]) ? r_maxb[r_ch] : prev_raw;
        diff        = (cur_entry > prev_entry) ? cur_entry - prev_entry
                                               : prev_entry - cur_entry;
        target_prod = r_master * cur_entry;
        span_prod   = r_master * diff;
        target      = target_prod[2*BRIGHT_W-1:BRIGHT_W];
        b_now       = r_b[r_ch];
        darken      = target < b_now;
        steps       = darken ? {b_now, 1'b0} - STEP_W'(1) : {b_now, 1'b0} + STEP_W'(1);
        cd_now      = r_cd[r_ch];
    end

    // Products that feed the divider.
    assign ft_prod = r_fade * r_ticks;
    assign ct_prod = cd_now * r_pwm;

    // Divider operand selection.
    always_comb begin
        div_start    = (i_cmd.load_cd & (r_span != '0)) | i_cmd.load_time;
        div_dividend = i_cmd.load_time ? ct_prod : DIV_W'(ft_prod);
        div_divisor  = i_cmd.load_time ? r_steps : DVSR_W'(r_span);
    end

    ccfs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade  <= FADE_RESET;
            r_ticks <= TICKS_RESET;
            r_pwm   <= PWM_RESET;
            for (int i = 0; i < CHANNELS; i++) begin
                r_maxb[i] <= MAXB_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FADE_TIME: r_fade     <= i_cfg_data[FADE_W-1:0];
                CFG_TICKS:     r_ticks    <= i_cfg_data[TICKS_W-1:0];
                CFG_PWM:       r_pwm      <= i_cfg_data[PWM_W-1:0];
                CFG_MAX_0:     r_maxb[0]  <= i_cfg_data[BRIGHT_W-1:0];
                CFG_MAX_1:     r_maxb[1]  <= i_cfg_data[BRIGHT_W-1:0];
                CFG_MAX_2:     r_maxb[2]  <= i_cfg_data[BRIGHT_W-1:0];
                CFG_MAX_3:     r_maxb[3]  <= i_cfg_data[BRIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Color position, active flag and countdowns.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= COLOR_RESET;
            r_prev   <= PREV_RESET;
            r_active <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cd[i] <= '0;
            end
        end else begin
            if (i_cmd.clear_active && in_fire) begin
                r_active <= 1'b0;
            end
            if (i_cmd.advance) begin
                r_active <= 1'b1;
                r_prev   <= r_cur;
                r_cur    <= (r_cur >= COLOR_LAST) ? '0 : r_cur + 1'b1;
            end
            if (i_cmd.scan && (cd_now != '0)) begin
                r_cd[r_ch] <= cd_now - 1'b1;
            end
            if (i_cmd.load_cd && (r_span == '0)) begin
                r_cd[r_ch] <= CD_W'(1);
            end
            if (i_cmd.store_cd) begin
                r_cd[r_ch] <= div_q[CD_W-1:0];
            end
        end
    end

    // Tick capture and channel scan position.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b[0]   <= i_in.brightness_0;
            r_b[1]   <= i_in.brightness_1;
            r_b[2]   <= i_in.brightness_2;
            r_b[3]   <= i_in.brightness_3;
            r_master <= i_in.master_brightness;
            r_ch     <= '0;
        end else if (i_cmd.ch_next) begin
            r_ch <= r_ch + 1'b1;
        end
        if (i_cmd.scan) begin
            r_span   <= span_prod[2*BRIGHT_W-1:BRIGHT_W];
            r_steps  <= steps;
            r_darken <= darken;
        end
        if (i_cmd.store_time) begin
            r_time <= (div_q[DIV_W-1:TIME_W] != '0) ? '1 : div_q[TIME_W-1:0];
        end
    end

    // Output register, so a finished command can wait while the next tick runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_channel <= r_ch;
            r_o_steps   <= r_steps;
            r_o_dir     <= r_darken;
            r_o_time    <= r_time;
            r_o_color   <= r_cur;
        end
    end

    assign i_in.ready        = i_cmd.in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.channel     = r_o_channel;
    assign o_out.step_count  = r_o_steps;
    assign o_out.direction   = r_o_dir;
    assign o_out.step_time   = r_o_time;
    assign o_out.color_index = r_o_color;

    // Status toward the controller.
    always_comb begin
        o_status.in_valid   = i_in.valid;
        o_status.in_kind    = i_in.kind;
        o_status.active     = r_active;
        o_status.off_target = target != b_now;
        o_status.cd_zero    = cd_now == '0;
        o_status.last_ch    = r_ch == CH_W'(CHANNELS - 1);
        o_status.span_zero  = r_span == '0;
        o_status.div_done   = div_done;
        o_status.out_free   = !r_out_valid || o_out.ready;
    end

endmodule

`default_nettype wire

// ===== design/ccfs_controller.sv =====
// Controller state machine: channel scan, the two reload divisions and command emission.
`default_nettype none

module ccfs_controller (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ccfs_pkg::t_dp_status i_status,
    output ccfs_pkg::t_ctrl_cmd       o_cmd
);
    import ccfs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SCAN      = 7'b0000010,
        ST_LOAD_CD   = 7'b0000100,
        ST_DIV_CD    = 7'b0001000,
        ST_LOAD_TIME = 7'b0010000,
        ST_DIV_TIME  = 7'b0100000,
        ST_EMIT      = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_status.in_valid) begin
                    if (i_status.in_kind) begin
                        o_cmd.clear_active = 1'b1;
                    end else if (!i_status.active) begin
                        o_cmd.advance = 1'b1;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.off_target) begin
                    // The first channel off target ends the scan.
                    n_state = i_status.cd_zero ? ST_LOAD_CD : ST_IDLE;
                end else if (i_status.last_ch) begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_cmd.ch_next = 1'b1;
                end
            end
            ST_LOAD_CD: begin
                o_cmd.load_cd = 1'b1;
                n_state       = i_status.span_zero ? ST_LOAD_TIME : ST_DIV_CD;
            end
            ST_DIV_CD: begin
                if (i_status.div_done) begin
                    o_cmd.store_cd = 1'b1;
                    n_state        = ST_LOAD_TIME;
                end
            end
            ST_LOAD_TIME: begin
                o_cmd.load_time = 1'b1;
                n_state         = ST_DIV_TIME;
            end
            ST_DIV_TIME: begin
                if (i_status.div_done) begin
                    o_cmd.store_time = 1'b1;
                    n_state          = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/color_cycle_fade_sequencer.sv =====
// Top level of the RGBW color cycle fade sequencer.
//
//  Channel     Dir  Beat contents
//  i_in        in   kind, brightness_0..3, master_brightness
//  o_out       out  channel, step_count, direction, step_time, color_index
//  i_cfg_*     in   write enable, register index, write data (no read-back)
//
// A restart beat or a tick while inactive is handled in the idle state alone. An active
// tick scans one channel per cycle; a reload then runs both divisions (only the time
// division with a zero span) on the shared divider at two quotient bits a cycle, and
// waits for the divider's done flag before storing each result.
// Reset is synchronous, active low. A dim command waits in the output register; the
// next tick is taken meanwhile, and a new command stalls only in the emit state.
`default_nettype none

module color_cycle_fade_sequencer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ccfs_in_if.sink                              i_in,
    ccfs_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [ccfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ccfs_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ccfs_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    ccfs_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ccfs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire

// ===== design/ccfs_checker.sv =====
// Port-level assertions for the color fade sequencer and the bind that attaches them.
`default_nettype none

module ccfs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  i_out_channel,
    input wire logic [8:0]  i_out_step_count,
    input wire logic        i_out_direction,
    input wire logic [31:0] i_out_step_time,
    input wire logic [3:0]  i_out_color_index
);

    // A stalled dim command beat holds its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_channel)
            && $stable(i_out_step_count) && $stable(i_out_direction)
            && $stable(i_out_step_time) && $stable(i_out_color_index))
        else $error("dim command beat changed while stalled");

    // The square-law step count is always odd, so never zero.
    a_steps_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_step_count[0])
        else $error("even step count in dim command");

    // The color index always names a table row.
    a_color_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_color_index <= 4'd10)
        else $error("color index beyond table");

    // Reset leaves no command pending.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind color_cycle_fade_sequencer ccfs_checker u_ccfs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_channel     (o_out.channel),
    .i_out_step_count  (o_out.step_count),
    .i_out_direction   (o_out.direction),
    .i_out_step_time   (o_out.step_time),
    .i_out_color_index (o_out.color_index)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the color cycle fade sequencer: random ticks, dim command checks.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccfs_pkg::*;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 400000;

    // One tick beat as the sender sees it.
    typedef struct packed {
        logic                               kind;
        logic [CHANNELS-1:0][BRIGHT_W-1:0]  bright;
        logic [BRIGHT_W-1:0]                master;
    } tick_beat_t;

    // One dim command beat.
    typedef struct packed {
        logic [CH_W-1:0]    channel;
        logic [STEP_W-1:0]  step_count;
        logic               direction;
        logic [TIME_W-1:0]  step_time;
        logic [COLOR_W-1:0] color_index;
    } dim_cmd_t;

    typedef struct packed {
        logic [FADE_W-1:0]                 fade_time;
        logic [TICKS_W-1:0]                ticks_per_second;
        logic [PWM_W-1:0]                  pwm_cases;
        logic [CHANNELS-1:0][BRIGHT_W-1:0] max_bright;
    } fade_cfg_t;

    typedef struct packed {
        logic [CHANNELS-1:0][CD_W-1:0] countdown;
        logic [COLOR_W-1:0]            cur_color;
        logic [COLOR_W-1:0]            prev_color;
        logic                          active;
    } seq_state_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ccfs_in_if  tick_if ();
    ccfs_out_if dim_if ();

    color_cycle_fade_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_if),
        .o_out       (dim_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fade_cfg_t   fade_cfg;
    seq_state_t  model_state;
    seq_state_t  gen_state;
    tick_beat_t  tick_queue [$];
    dim_cmd_t    dim_expect [$];
    tick_beat_t  beat_on_bus;
    dim_cmd_t    accepted_cmd;
    logic [BRIGHT_W-1:0] gen_master;
    int          failures;
    int          cycle_count;
    int          send_gap;
    int          hold_gap;
    bit          calm;

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Table level of a channel, clamped by its brightness limit.
    function automatic logic [BRIGHT_W-1:0] fade_level(input logic [COLOR_W-1:0] color,
                                                       input int ch);
        logic [BRIGHT_W-1:0] v;
        v = COLOR_TABLE[color][ch];
        if (v > fade_cfg.max_bright[ch]) begin
            v = fade_cfg.max_bright[ch];
        end
        return v;
    endfunction

    function automatic logic [BRIGHT_W-1:0] target_level(input logic [COLOR_W-1:0] color,
                                                         input int ch,
                                                         input logic [BRIGHT_W-1:0] master);
        return 8'((16'(master) * 16'(fade_level(color, ch))) >> 8);
    endfunction

    function automatic seq_state_t fresh_state();
        seq_state_t st;
        st.countdown  = '0;
        st.cur_color  = COLOR_RESET;
        st.prev_color = PREV_RESET;
        st.active     = 1'b0;
        return st;
    endfunction

    // Advances the sequencer by one beat; returns 1 when a dim command comes out.
    function automatic bit predict_tick(inout seq_state_t st, input tick_beat_t beat,
                                        output dim_cmd_t cmd);
        bit                  fading;
        bit                  made;
        bit                  darken;
        logic [BRIGHT_W-1:0] b;
        logic [BRIGHT_W-1:0] tgt;
        logic [BRIGHT_W-1:0] lvl_new;
        logic [BRIGHT_W-1:0] lvl_old;
        logic [BRIGHT_W-1:0] diff;
        logic [BRIGHT_W-1:0] span;
        logic [STEP_W-1:0]   steps;
        logic [CD_W-1:0]     cd;
        logic [63:0]         t;
        fading = 1'b0;
        made   = 1'b0;
        cmd    = '0;
        if (beat.kind == KIND_RESTART) begin
            st.active = 1'b0;
            return 1'b0;
        end
        if (st.active) begin
            for (int ch = 0; ch < CHANNELS && !fading; ch++) begin
                b   = beat.bright[ch];
                tgt = target_level(st.cur_color, ch, beat.master);
                if (tgt != b) begin
                    fading = 1'b1;
                end
                if (st.countdown[ch] != '0) begin
                    st.countdown[ch] = st.countdown[ch] - 32'd1;
                end else if (tgt != b) begin
                    // Reload from the span between the old and new color.
                    lvl_new = fade_level(st.cur_color, ch);
                    lvl_old = fade_level(st.prev_color, ch);
                    diff    = (lvl_new > lvl_old) ? lvl_new - lvl_old : lvl_old - lvl_new;
                    span    = 8'((16'(beat.master) * 16'(diff)) >> 8);
                    if (span != '0) begin
                        cd = (32'(fade_cfg.fade_time) * 32'(fade_cfg.ticks_per_second))
                             / 32'(span);
                    end else begin
                        cd = 32'd1;
                    end
                    st.countdown[ch] = cd;
                    darken = (tgt < b);
                    steps  = darken ? 9'({b, 1'b0} - 9'd1) : 9'({b, 1'b0} + 9'd1);
                    t      = (64'(cd) * 64'(fade_cfg.pwm_cases)) / 64'(steps);
                    cmd.channel     = 2'(ch);
                    cmd.step_count  = steps;
                    cmd.direction   = darken;
                    cmd.step_time   = (t > 64'h0000_0000_FFFF_FFFF) ? '1 : t[31:0];
                    cmd.color_index = st.cur_color;
                    made = 1'b1;
                end
            end
        end
        if (!st.active || !fading) begin
            st.active     = 1'b1;
            st.prev_color = st.cur_color;
            st.cur_color  = (st.cur_color == COLOR_LAST) ? '0 : st.cur_color + 4'd1;
        end
        return made;
    endfunction

    // Queues a beat for the driver, tracking the sequencer state it will meet.
    function automatic bit push_tick(input tick_beat_t beat);
        dim_cmd_t cmd;
        bit       made;
        made = predict_tick(gen_state, beat, cmd);
        tick_queue.push_back(beat);
        return made;
    endfunction

    function automatic tick_beat_t uniform_tick(input logic [BRIGHT_W-1:0] level,
                                                input logic [BRIGHT_W-1:0] master);
        tick_beat_t beat;
        beat.kind   = KIND_TICK;
        beat.bright = {CHANNELS{level}};
        beat.master = master;
        return beat;
    endfunction

    function automatic tick_beat_t on_target_tick(input logic [BRIGHT_W-1:0] master);
        tick_beat_t beat;
        beat.kind   = KIND_TICK;
        beat.master = master;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            beat.bright[ch] = target_level(gen_state.cur_color, ch, master);
        end
        return beat;
    endfunction

    function automatic logic [BRIGHT_W-1:0] pick_master();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 8'h00;
        end else if (pick == 1) begin
            return 8'hFF;
        end else if (pick == 2) begin
            return 8'($urandom_range(1, 4));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly channels on their target, so colors advance; the rest drift or are random.
    function automatic tick_beat_t random_tick();
        tick_beat_t          beat;
        int                  pick;
        logic [BRIGHT_W-1:0] tgt;
        if ($urandom_range(0, 9) == 0) begin
            gen_master = pick_master();
        end
        beat.kind   = ($urandom_range(0, 24) == 0) ? KIND_RESTART : KIND_TICK;
        beat.master = gen_master;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            tgt  = target_level(gen_state.cur_color, ch, gen_master);
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                beat.bright[ch] = tgt;
            end else if (pick < 9) begin
                beat.bright[ch] = 8'($urandom_range(0, 255));
            end else begin
                beat.bright[ch] = ($urandom_range(0, 1) == 1) ? tgt + 8'd1 : tgt - 8'd1;
            end
        end
        return beat;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FADE_TIME: fade_cfg.fade_time        = val;
            CFG_TICKS:     fade_cfg.ticks_per_second = val;
            CFG_PWM:       fade_cfg.pwm_cases        = val[PWM_W-1:0];
            CFG_MAX_0:     fade_cfg.max_bright[0]    = val[BRIGHT_W-1:0];
            CFG_MAX_1:     fade_cfg.max_bright[1]    = val[BRIGHT_W-1:0];
            CFG_MAX_2:     fade_cfg.max_bright[2]    = val[BRIGHT_W-1:0];
            CFG_MAX_3:     fade_cfg.max_bright[3]    = val[BRIGHT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_setup(input int fade, input int ticks, input int pwm,
                               input int lim0, input int lim1, input int lim2, input int lim3);
        write_reg(CFG_FADE_TIME, 16'(fade));
        write_reg(CFG_TICKS, 16'(ticks));
        write_reg(CFG_PWM, 16'(pwm));
        write_reg(CFG_MAX_0, 16'(lim0));
        write_reg(CFG_MAX_1, 16'(lim1));
        write_reg(CFG_MAX_2, 16'(lim2));
        write_reg(CFG_MAX_3, 16'(lim3));
    endtask

    // Waits until every beat is sent and every command seen, then lets the block settle.
    task automatic wait_idle();
        while (tick_queue.size() != 0 || tick_if.valid || dim_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            void'(push_tick(random_tick()));
        end
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // Driver: sends queued tick beats and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                if (predict_tick(model_state, beat_on_bus, accepted_cmd)) begin
                    dim_expect.push_back(accepted_cmd);
                end
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    tick_if.valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    beat_on_bus = tick_queue.pop_front();
                    tick_if.valid             <= 1'b1;
                    tick_if.kind              <= beat_on_bus.kind;
                    tick_if.brightness_0      <= beat_on_bus.bright[0];
                    tick_if.brightness_1      <= beat_on_bus.bright[1];
                    tick_if.brightness_2      <= beat_on_bus.bright[2];
                    tick_if.brightness_3      <= beat_on_bus.bright[3];
                    tick_if.master_brightness <= beat_on_bus.master;
                    if (!calm && $urandom_range(0, 3) == 0) begin
                        send_gap = $urandom_range(1, 6);
                    end
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each dim command beat against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dim_if.ready <= 1'b0;
        end else begin
            if (dim_if.valid && dim_if.ready) begin
                if (dim_expect.size() == 0) begin
                    $error("unexpected dim command on channel %0d", dim_if.channel);
                    failures++;
                end else begin
                    accepted_cmd = dim_expect.pop_front();
                    check_field("channel", 64'(accepted_cmd.channel), 64'(dim_if.channel));
                    check_field("step_count", 64'(accepted_cmd.step_count),
                                64'(dim_if.step_count));
                    check_field("direction", 64'(accepted_cmd.direction),
                                64'(dim_if.direction));
                    check_field("step_time", 64'(accepted_cmd.step_time),
                                64'(dim_if.step_time));
                    check_field("color_index", 64'(accepted_cmd.color_index),
                                64'(dim_if.color_index));
                end
            end
            if (hold_gap > 0) begin
                hold_gap--;
                dim_if.ready <= 1'b0;
            end else begin
                dim_if.ready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) begin
                    hold_gap = $urandom_range(1, 6);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        int tries;
        i_rst_n   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        tick_if.valid             = 1'b0;
        tick_if.kind              = KIND_TICK;
        tick_if.brightness_0      = '0;
        tick_if.brightness_1      = '0;
        tick_if.brightness_2      = '0;
        tick_if.brightness_3      = '0;
        tick_if.master_brightness = '0;
        dim_if.ready              = 1'b0;
        failures    = 0;
        cycle_count = 0;
        send_gap    = 0;
        hold_gap    = 0;
        calm        = 1'b0;
        gen_master  = 8'hFF;
        fade_cfg.fade_time        = FADE_RESET;
        fade_cfg.ticks_per_second = TICKS_RESET;
        fade_cfg.pwm_cases        = PWM_RESET;
        fade_cfg.max_bright       = {CHANNELS{MAXB_RESET}};
        model_state = fresh_state();
        gen_state   = fresh_state();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats at reset settings: restarts, extremes, then a walk over all colors.
        void'(push_tick({KIND_RESTART, {CHANNELS{8'hFF}}, 8'hFF}));
        void'(push_tick(uniform_tick(8'hFF, 8'hFF)));
        void'(push_tick(uniform_tick(8'h00, 8'hFF)));
        void'(push_tick(uniform_tick(8'hFF, 8'hFF)));
        void'(push_tick(uniform_tick(8'h00, 8'h00)));
        void'(push_tick(uniform_tick(8'hFF, 8'h00)));
        void'(push_tick({KIND_RESTART, {CHANNELS{8'h00}}, 8'h00}));
        for (int k = 0; k < COLOR_COUNT + 1; k++) begin
            void'(push_tick(on_target_tick(8'hFF)));
        end
        void'(push_tick(uniform_tick(8'h55, 8'h80)));
        void'(push_tick(uniform_tick(8'hAA, 8'h80)));
        wait_idle();

        // Shortest fades: every reload with a nonzero span gives a zero countdown.
        write_setup(0, 1, 1, 255, 255, 255, 255);
        run_random(220);
        wait_idle();

        // Longest fades; a small master gives a tiny span and a saturated step time.
        write_setup(65535, 65535, 255, 255, 255, 255, 255);
        tries = 0;
        while (tries < COLOR_COUNT + 1 && !push_tick(uniform_tick(8'h00, 8'h02))) begin
            tries++;
        end
        run_random(40);
        wait_idle();

        // Zero tick rate and zero scale factor, with limits at both ends.
        write_setup(5, 0, 0, 0, 255, 0, 255);
        run_random(150);
        wait_idle();

        write_setup(3, 2, $urandom_range(1, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        run_random(200);
        wait_idle();

        // Closing stretch with both sides at full rate.
        calm = 1'b1;
        write_setup($urandom_range(0, 20), $urandom_range(1, 4), $urandom_range(1, 255),
                    $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
        run_random(140);
        wait_idle();

        if (failures == 0 && dim_expect.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
